// ===== hdl/mpbm_pkg.sv =====
package mpbm_pkg;

  localparam int NODES      = 256;
  localparam int ALPHABET   = 256;
  localparam int MAX_DEPTH  = 63;

  localparam int GOTO_DEPTH = NODES * ALPHABET;
  localparam int GOTO_AW    = $clog2(GOTO_DEPTH);
  localparam int NODE_AW    = $clog2(NODES);
  localparam int HOP_W      = $clog2(MAX_DEPTH + 1);
  localparam int GOTO_W     = 9;
  localparam int INFO_W     = 9;

  typedef enum logic [1:0] {
    MODE_GOTO = 2'd0,
    MODE_INFO = 2'd1,
    MODE_TEXT = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0]  node;
    logic [31:0] match_end;
    logic        run_last;
  } result_t;

  function automatic logic node_in_range(input logic [7:0] n);
    return 32'(n) < NODES;
  endfunction

  function automatic logic byte_in_range(input logic [7:0] b);
    return 32'(b) < ALPHABET;
  endfunction

  function automatic logic [GOTO_AW-1:0] goto_addr(input logic [7:0] n, input logic [7:0] b);
    return GOTO_AW'(32'(n) * ALPHABET + 32'(b));
  endfunction

endpackage

// ===== hdl/mpbm_ram.sv =====
module mpbm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/mpbm_out_buf.sv =====
module mpbm_out_buf
  import mpbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  result_t     push_res,
  output logic        out_free,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [7:0]  match_node,
  output logic [31:0] match_end,
  output logic        run_last
);

  result_t res;

  assign out_free   = !res_valid || res_ready;
  assign match_node = res.node;
  assign match_end  = res.match_end;
  assign run_last   = res.run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res <= push_res;
    end
  end

endmodule

// ===== hdl/mpbm_walker.sv =====
module mpbm_walker
  import mpbm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         mode,
  input  logic [7:0]         node,
  input  logic [7:0]         byte_value,
  input  logic [7:0]         target_node,
  input  logic               entry_valid,
  input  logic               final_mark,
  input  logic               text_last,
  output logic               goto_we,
  output logic [GOTO_AW-1:0] goto_waddr,
  output logic [GOTO_W-1:0]  goto_wdata,
  output logic [GOTO_AW-1:0] goto_raddr,
  input  logic [GOTO_W-1:0]  goto_rdata,
  output logic               info_we,
  output logic [NODE_AW-1:0] info_waddr,
  output logic [INFO_W-1:0]  info_wdata,
  output logic [NODE_AW-1:0] info_raddr,
  input  logic [INFO_W-1:0]  info_rdata,
  output logic               rd_en,
  input  logic               out_free,
  output logic               push,
  output result_t            push_res
);

  typedef enum logic [2:0] {CLEAR, IDLE, WALK, ROOT, FLUSH} state_t;

  state_t             state;
  logic [GOTO_AW-1:0] clr_addr;
  logic [7:0]         cur;
  logic [31:0]        bytes_seen;
  logic [HOP_W-1:0]   hops;
  logic [7:0]         b_q;
  logic               byte_ok;
  logic               last_q;
  logic               landed;
  logic               done_q;
  logic               pend_valid;
  logic [7:0]         pend_node;
  logic [31:0]        pend_end;
  logic               node_vld [NODES];
  logic               info_ok;

  mode_t      req_mode;
  logic       accept;
  logic       cur_ok;
  logic       cur_fin;
  logic       stall;
  logic       e_valid;
  logic       consume;
  logic       hop;
  logic       go_root;
  logic [7:0] nxt;
  logic [7:0] rd_node;

  assign req_mode  = mode_t'(mode);
  assign req_ready = (state == IDLE);
  assign accept    = req_valid && req_ready;
  assign cur_ok    = node_in_range(cur);
  assign cur_fin   = landed && cur_ok && info_ok && info_rdata[8];
  assign stall     = (state == WALK) && cur_fin && pend_valid && !out_free;
  assign e_valid   = cur_ok && byte_ok && goto_rdata[8];

  // step from the current node
  always_comb begin
    consume = 1'b0;
    hop     = 1'b0;
    go_root = 1'b0;
    nxt     = cur;
    if (state == ROOT) begin
      consume = 1'b1;
      nxt     = (byte_ok && goto_rdata[8]) ? goto_rdata[7:0] : 8'd0;
    end else if (e_valid) begin
      consume = 1'b1;
      nxt     = goto_rdata[7:0];
    end else if (cur == 8'd0) begin
      consume = 1'b1;
      nxt     = 8'd0;
    end else if (32'(hops) < MAX_DEPTH) begin
      hop = 1'b1;
      nxt = cur_ok ? info_rdata[7:0] : 8'd0;
    end else begin
      go_root = 1'b1;
    end
  end

  // table ports
  always_comb begin
    goto_we    = 1'b0;
    goto_waddr = goto_addr(node, byte_value);
    goto_wdata = {entry_valid, entry_valid ? target_node : 8'd0};
    info_we    = accept && (req_mode == MODE_INFO) && node_in_range(node);
    info_waddr = NODE_AW'(node);
    info_wdata = {final_mark, target_node};
    rd_en      = 1'b0;
    rd_node    = nxt;
    goto_raddr = goto_addr(nxt, b_q);
    if (state == CLEAR) begin
      goto_we    = 1'b1;
      goto_waddr = clr_addr;
      goto_wdata = '0;
    end else if (accept && (req_mode == MODE_GOTO)) begin
      goto_we = node_in_range(node) && byte_in_range(byte_value);
    end
    unique case (state)
      IDLE: begin
        rd_en      = accept && (req_mode == MODE_TEXT);
        rd_node    = cur;
        goto_raddr = goto_addr(cur, byte_value);
      end
      WALK: begin
        rd_en = !stall && !done_q;
        if (go_root) begin
          goto_raddr = goto_addr(8'd0, b_q);
        end
      end
      ROOT: begin
        rd_en = 1'b1;
      end
      CLEAR, FLUSH: begin
        rd_en = 1'b0;
      end
    endcase
    info_raddr = NODE_AW'(rd_node);
  end

  always_comb begin
    push     = 1'b0;
    push_res = '{node: pend_node, match_end: pend_end, run_last: 1'b0};
    if (state == WALK) begin
      push = cur_fin && pend_valid && out_free;
    end else if (state == FLUSH) begin
      push              = pend_valid && out_free;
      push_res.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      info_ok <= node_vld[NODE_AW'(rd_node)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CLEAR;
      clr_addr   <= '0;
      cur        <= 8'd0;
      bytes_seen <= 32'd0;
      hops       <= '0;
      landed     <= 1'b0;
      done_q     <= 1'b0;
      pend_valid <= 1'b0;
      for (int i = 0; i < NODES; i++) begin
        node_vld[i] <= 1'b0;
      end
    end else begin
      unique case (state)
        CLEAR: begin
          clr_addr <= clr_addr + GOTO_AW'(1);
          if (clr_addr == GOTO_AW'(GOTO_DEPTH - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (info_we) begin
            node_vld[NODE_AW'(node)] <= 1'b1;
          end
          if (accept && (req_mode == MODE_TEXT)) begin
            b_q     <= byte_value;
            byte_ok <= byte_in_range(byte_value);
            last_q  <= text_last;
            hops    <= '0;
            landed  <= 1'b0;
            done_q  <= 1'b0;
            state   <= WALK;
          end
        end
        WALK: begin
          if (!stall) begin
            if (cur_fin) begin
              pend_valid <= 1'b1;
              pend_node  <= cur;
              pend_end   <= bytes_seen;
            end
            if (done_q) begin
              state <= FLUSH;
            end else if (go_root) begin
              state <= ROOT;
            end else begin
              cur    <= nxt;
              landed <= 1'b1;
              done_q <= consume;
              if (consume) begin
                bytes_seen <= bytes_seen + 32'd1;
              end
              if (hop) begin
                hops <= hops + HOP_W'(1);
              end
            end
          end
        end
        ROOT: begin
          cur        <= nxt;
          bytes_seen <= bytes_seen + 32'd1;
          landed     <= 1'b1;
          done_q     <= 1'b1;
          state      <= WALK;
        end
        FLUSH: begin
          if (!pend_valid || out_free) begin
            pend_valid <= 1'b0;
            if (last_q) begin
              cur        <= 8'd0;
              bytes_seen <= 32'd0;
            end
            state <= IDLE;
          end
        end
      endcase
    end
  end

  a_push_free: assert property (@(posedge clk) disable iff (rst) push |-> out_free)
    else $error("result pushed into a full output register");

  a_hop_cap: assert property (@(posedge clk) disable iff (rst) 32'(hops) <= MAX_DEPTH)
    else $error("failure hop count beyond cap");

  a_text_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && req_mode == MODE_TEXT) |=> (state == WALK))
    else $error("text request did not start a walk");

  a_text_end: assert property (@(posedge clk) disable iff (rst)
    (state == FLUSH && (!pend_valid || out_free) && last_q)
      |=> (cur == 8'd0 && bytes_seen == 32'd0))
    else $error("text end did not return to root");

endmodule

// ===== hdl/multi_pattern_byte_matcher_core.sv =====
// channel   handshake              payload
// request   req_valid / req_ready  mode node byte_value target_node entry_valid
//                                  final_mark text_last
// result    res_valid / res_ready  match_node match_end run_last
//
// table writes are taken while idle; a text byte walks its failure hops one per cycle,
// with one more step when the hop cap sends the walk back to the root, the goto and node
// memory reads setting that pace; a full result register can stall the walk.
// after reset the goto memory is swept clear, one entry a cycle, with req_ready low.
// a full result register holds the walk when a further match is pending, and holds
// the last match of a byte until it drains; requests are taken whenever the walker is idle.
module multi_pattern_byte_matcher_core
  import mpbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  node,
  input  logic [7:0]  byte_value,
  input  logic [7:0]  target_node,
  input  logic        entry_valid,
  input  logic        final_mark,
  input  logic        text_last,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [7:0]  match_node,
  output logic [31:0] match_end,
  output logic        run_last
);

  logic               goto_we;
  logic [GOTO_AW-1:0] goto_waddr;
  logic [GOTO_W-1:0]  goto_wdata;
  logic [GOTO_AW-1:0] goto_raddr;
  logic [GOTO_W-1:0]  goto_rdata;
  logic               info_we;
  logic [NODE_AW-1:0] info_waddr;
  logic [INFO_W-1:0]  info_wdata;
  logic [NODE_AW-1:0] info_raddr;
  logic [INFO_W-1:0]  info_rdata;
  logic               rd_en;
  logic               out_free;
  logic               push;
  result_t            push_res;

  mpbm_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .mode        (mode),
    .node        (node),
    .byte_value  (byte_value),
    .target_node (target_node),
    .entry_valid (entry_valid),
    .final_mark  (final_mark),
    .text_last   (text_last),
    .goto_we     (goto_we),
    .goto_waddr  (goto_waddr),
    .goto_wdata  (goto_wdata),
    .goto_raddr  (goto_raddr),
    .goto_rdata  (goto_rdata),
    .info_we     (info_we),
    .info_waddr  (info_waddr),
    .info_wdata  (info_wdata),
    .info_raddr  (info_raddr),
    .info_rdata  (info_rdata),
    .rd_en       (rd_en),
    .out_free    (out_free),
    .push        (push),
    .push_res    (push_res)
  );

  // goto entries: valid bit and target
  mpbm_ram #(.DEPTH(GOTO_DEPTH), .WIDTH(GOTO_W)) u_goto_ram (
    .clk   (clk),
    .we    (goto_we),
    .waddr (goto_waddr),
    .wdata (goto_wdata),
    .re    (rd_en),
    .raddr (goto_raddr),
    .rdata (goto_rdata)
  );

  // per node: final flag and failure link
  mpbm_ram #(.DEPTH(NODES), .WIDTH(INFO_W)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (info_waddr),
    .wdata (info_wdata),
    .re    (rd_en),
    .raddr (info_raddr),
    .rdata (info_rdata)
  );

  mpbm_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_res   (push_res),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .match_node (match_node),
    .match_end  (match_end),
    .run_last   (run_last)
  );

endmodule
